// File: hw/rtl/fa_pkg.sv
// fa_pkg: shared constants for the fraction alu (command codes, field widths)
// no dependencies; used by the interfaces, the top level and the bench

package fa_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int CMD_W         = 3;
    localparam int NUM_OUT_W     = 33;
    localparam int DEN_OUT_W     = 32;

    localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RED = 3'd4;

    // any code with this bit set reduces the first fraction
    localparam int CMD_RED_BIT = 2;

endpackage

// File: hw/rtl/fa_if.sv
// fa_in_if / fa_out_if: valid/ready channels of the fraction alu
// depends on fa_pkg for widths

interface fa_in_if #(
    parameter int OPERAND_WIDTH = fa_pkg::OPERAND_WIDTH
);
    logic                            valid;
    logic                            ready;
    logic [fa_pkg::CMD_W-1:0]        cmd;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;

    modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

interface fa_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [fa_pkg::NUM_OUT_W-1:0] result_num;
    logic signed [fa_pkg::DEN_OUT_W-1:0] result_den;
    logic                                status;

    modport source (output valid, result_num, result_den, status, input ready);
    modport sink   (input valid, result_num, result_den, status, output ready);
endinterface

// File: hw/rtl/fraction_alu_with_reduction_top.sv
// channel   dir  modport  word
// i_in      in   sink     cmd, a_num, a_den, b_num, b_den
// o_out     out  source   result_num, result_den, status
//
// one word at a time: reduce skips the shared multiplier; mul/div use it in S_MUL0 and
// S_MUL1, add/sub also in S_MUL2 and then S_SUM; then S_LAUNCH and fa_gcd: a binary gcd
// loop, then two restoring divisions of 2*OPERAND_WIDTH-bit magnitudes
// a zero numerator skips the gcd
// synchronous active-low reset clears the sequencer and the output valid; no ready in reset
// the result waits in an output register while the next word is taken; a full one stalls
// depends on fa_pkg, fa_if.sv and fa_gcd

module fraction_alu_with_reduction_top #(
    parameter int OPERAND_WIDTH = fa_pkg::OPERAND_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fa_in_if.sink      i_in,
    fa_out_if.source   o_out
);

    localparam int W    = OPERAND_WIDTH;
    localparam int MW   = 2 * W;
    localparam int NW   = fa_pkg::NUM_OUT_W;
    localparam int DW   = fa_pkg::DEN_OUT_W;
    localparam int MAXW = (MW > NW) ? MW : NW;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL0   = 3'd1;
    localparam logic [2:0] S_MUL1   = 3'd2;
    localparam logic [2:0] S_MUL2   = 3'd3;
    localparam logic [2:0] S_SUM    = 3'd4;
    localparam logic [2:0] S_LAUNCH = 3'd5;
    localparam logic [2:0] S_WAIT   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    logic [2:0]                r_state;
    logic [fa_pkg::CMD_W-1:0]  r_cmd;
    logic                      r_an_s, r_ad_s, r_bn_s, r_bd_s;
    logic [W-1:0]              r_an_m, r_ad_m, r_bn_m, r_bd_m;
    logic                      r_num_neg, r_den_neg, r_t_neg;
    logic [MW-1:0]             r_num_mag, r_den_mag, r_t_mag;
    logic                      r_stat;

    logic                      r_out_valid;
    logic signed [NW-1:0]      r_res_num;
    logic signed [DW-1:0]      r_res_den;
    logic                      r_res_stat;

    logic                      in_fire;
    logic [W-1:0]              mul_x, mul_y;
    logic                      mul_sx, mul_sy;
    logic [MW-1:0]             prod;
    logic                      prod_neg;

    logic                      sum_same, sum_ge;
    logic [MW-1:0]             sum_mag;
    logic                      sum_neg;

    logic                      gcd_start, gcd_done;
    logic [MW-1:0]             gcd_qn, gcd_qd;

    logic [MAXW-1:0]           num_ext, den_ext, num_val, den_val;
    logic                      out_free;

    assign in_fire    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE) && i_rst_n;
    assign out_free   = !r_out_valid || o_out.ready;

    // operand select for the shared multiplier
    always_comb begin
        unique case (r_state)
            S_MUL0: begin
                mul_x  = r_an_m;
                mul_sx = r_an_s;
                mul_y  = (r_cmd == fa_pkg::CMD_MUL) ? r_bn_m : r_bd_m;
                mul_sy = (r_cmd == fa_pkg::CMD_MUL) ? r_bn_s : r_bd_s;
            end
            S_MUL1: begin
                mul_x  = r_ad_m;
                mul_sx = r_ad_s;
                mul_y  = (r_cmd == fa_pkg::CMD_DIV) ? r_bn_m : r_bd_m;
                mul_sy = (r_cmd == fa_pkg::CMD_DIV) ? r_bn_s : r_bd_s;
            end
            default: begin
                mul_x  = r_bn_m;
                mul_sx = r_bn_s;
                mul_y  = r_ad_m;
                mul_sy = r_ad_s;
            end
        endcase
        prod     = mul_x * mul_y;
        // second cross term of a subtract takes the opposite sign
        prod_neg = (prod != '0) && (mul_sx ^ mul_sy ^
                   ((r_state == S_MUL2) && (r_cmd == fa_pkg::CMD_SUB)));
    end

    // sign-magnitude add of the two cross terms
    always_comb begin
        sum_same = (r_num_neg == r_t_neg);
        sum_ge   = (r_num_mag >= r_t_mag);
        if (sum_same) begin
            sum_mag = r_num_mag + r_t_mag;
            sum_neg = r_num_neg;
        end else if (sum_ge) begin
            sum_mag = r_num_mag - r_t_mag;
            sum_neg = r_num_neg;
        end else begin
            sum_mag = r_t_mag - r_num_mag;
            sum_neg = r_t_neg;
        end
        if (sum_mag == '0) begin
            sum_neg = 1'b0;
        end
    end

    assign gcd_start = (r_state == S_LAUNCH) && (r_num_mag != '0);

    fa_gcd #(
        .MW (MW)
    ) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gcd_start),
        .i_num   (r_num_mag),
        .i_den   (r_den_mag),
        .o_done  (gcd_done),
        .o_q_num (gcd_qn),
        .o_q_den (gcd_qd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_cmd  <= i_in.cmd;
                        r_an_s <= i_in.a_num[W-1];
                        r_ad_s <= i_in.a_den[W-1];
                        r_bn_s <= i_in.b_num[W-1];
                        r_bd_s <= i_in.b_den[W-1];
                        r_an_m <= mag_of(i_in.a_num);
                        r_ad_m <= mag_of(i_in.a_den);
                        r_bn_m <= mag_of(i_in.b_num);
                        r_bd_m <= mag_of(i_in.b_den);
                        if (i_in.cmd[fa_pkg::CMD_RED_BIT]) begin
                            r_num_neg <= i_in.a_num[W-1];
                            r_den_neg <= i_in.a_den[W-1];
                            r_num_mag <= {{W{1'b0}}, mag_of(i_in.a_num)};
                            r_den_mag <= {{W{1'b0}}, mag_of(i_in.a_den)};
                            r_state   <= S_LAUNCH;
                        end else begin
                            r_state   <= S_MUL0;
                        end
                    end
                end
                S_MUL0: begin
                    r_num_mag <= prod;
                    r_num_neg <= prod_neg;
                    r_state   <= S_MUL1;
                end
                S_MUL1: begin
                    r_den_mag <= prod;
                    r_den_neg <= prod_neg;
                    if (r_cmd == fa_pkg::CMD_ADD || r_cmd == fa_pkg::CMD_SUB) begin
                        r_state <= S_MUL2;
                    end else begin
                        r_state <= S_LAUNCH;
                    end
                end
                S_MUL2: begin
                    r_t_mag <= prod;
                    r_t_neg <= prod_neg;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_num_mag <= sum_mag;
                    r_num_neg <= sum_neg;
                    r_state   <= S_LAUNCH;
                end
                S_LAUNCH: begin
                    r_stat <= (r_den_mag == '0);
                    if (r_num_mag == '0) begin
                        // zero numerator reads as 0/1
                        r_num_neg <= 1'b0;
                        r_den_neg <= 1'b0;
                        r_den_mag <= MW'(1);
                        r_state   <= S_DONE;
                    end else begin
                        r_state   <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (gcd_done) begin
                        r_num_mag <= gcd_qn;
                        r_den_mag <= gcd_qd;
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // apply signs and cut to the output field widths
    always_comb begin
        num_ext = MAXW'(r_num_mag);
        den_ext = MAXW'(r_den_mag);
        num_val = r_num_neg ? (~num_ext + 1'b1) : num_ext;
        den_val = r_den_neg ? (~den_ext + 1'b1) : den_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_res_num  <= num_val[NW-1:0];
            r_res_den  <= den_val[DW-1:0];
            r_res_stat <= r_stat;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.result_num = r_res_num;
    assign o_out.result_den = r_res_den;
    assign o_out.status     = r_res_stat;

    a_gcd_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gcd_done |-> (r_state == S_WAIT))
        else $error("top: gcd finished outside the wait state");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> r_out_valid)
        else $error("top: pending word dropped");

    a_zero_num_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (r_num_mag == '0)) |-> (r_den_mag == MW'(1) && !r_den_neg))
        else $error("top: zero numerator not reported as 0/1");

endmodule

// File: hw/rtl/fa_gcd.sv
// fa_gcd: binary gcd of two magnitudes, then both divided by it (restoring)
// one shared subtractor serves the gcd loop and both divisions; no package use

module fa_gcd #(
    parameter int MW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [MW-1:0] i_num,
    input  logic [MW-1:0] i_den,
    output logic          o_done,
    output logic [MW-1:0] o_q_num,
    output logic [MW-1:0] o_q_den
);

    localparam int CW = $clog2(MW);

    localparam logic [2:0] G_IDLE  = 3'd0;
    localparam logic [2:0] G_GCD   = 3'd1;
    localparam logic [2:0] G_SHIFT = 3'd2;
    localparam logic [2:0] G_DIVN  = 3'd3;
    localparam logic [2:0] G_DIVD  = 3'd4;
    localparam logic [2:0] G_DONE  = 3'd5;

    logic [2:0]    r_state;
    logic [MW-1:0] r_a, r_b, r_n, r_d, r_g, r_r, r_q, r_qn;
    logic [CW-1:0] r_k, r_cnt;

    logic          a_ge_b;
    logic [MW:0]   div_sh;
    logic [MW:0]   sub_x, sub_y;
    logic [MW+1:0] diff;
    logic          sub_ok;
    logic          last_step;
    logic [MW-1:0] q_next;

    assign a_ge_b    = (r_a >= r_b);
    assign div_sh    = {r_r, r_q[MW-1]};
    assign last_step = (r_cnt == CW'(MW - 1));

    // shared subtractor: |a-b| in the gcd loop, trial subtract in division
    always_comb begin
        if (r_state == G_GCD) begin
            sub_x = a_ge_b ? {1'b0, r_a} : {1'b0, r_b};
            sub_y = a_ge_b ? {1'b0, r_b} : {1'b0, r_a};
        end else begin
            sub_x = div_sh;
            sub_y = {1'b0, r_g};
        end
        diff   = {1'b0, sub_x} - {1'b0, sub_y};
        sub_ok = !diff[MW+1];
        q_next = {r_q[MW-2:0], sub_ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
        end else begin
            unique case (r_state) inside
                G_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_num;
                        r_b     <= i_den;
                        r_n     <= i_num;
                        r_d     <= i_den;
                        r_k     <= '0;
                        r_state <= G_GCD;
                    end
                end
                G_GCD: begin
                    if (r_a == '0 || r_b == '0) begin
                        r_g     <= r_a | r_b;
                        r_state <= G_SHIFT;
                    end else if (!r_a[0] && !r_b[0]) begin
                        r_a <= r_a >> 1;
                        r_b <= r_b >> 1;
                        r_k <= r_k + 1'b1;
                    end else if (!r_a[0]) begin
                        r_a <= r_a >> 1;
                    end else if (!r_b[0]) begin
                        r_b <= r_b >> 1;
                    end else if (a_ge_b) begin
                        r_a <= diff[MW-1:0];
                    end else begin
                        r_b <= diff[MW-1:0];
                    end
                end
                G_SHIFT: begin
                    // put back the common powers of two
                    r_g     <= r_g << r_k;
                    r_r     <= '0;
                    r_q     <= r_n;
                    r_cnt   <= '0;
                    r_state <= G_DIVN;
                end
                G_DIVN, G_DIVD: begin
                    r_r   <= sub_ok ? diff[MW-1:0] : div_sh[MW-1:0];
                    r_q   <= q_next;
                    r_cnt <= r_cnt + 1'b1;
                    if (last_step) begin
                        r_cnt <= '0;
                        if (r_state == G_DIVN) begin
                            r_qn    <= q_next;
                            r_r     <= '0;
                            r_q     <= r_d;
                            r_state <= G_DIVD;
                        end else begin
                            r_state <= G_DONE;
                        end
                    end
                end
                G_DONE: begin
                    r_state <= G_IDLE;
                end
                default: begin
                    r_state <= G_IDLE;
                end
            endcase
        end
    end

    assign o_done  = (r_state == G_DONE);
    assign o_q_num = r_qn;
    assign o_q_den = r_q;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == G_IDLE))
        else $error("fa_gcd: start while busy");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == G_DIVN || r_state == G_DIVD) |-> (r_r < r_g))
        else $error("fa_gcd: remainder not below divisor");

    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == G_SHIFT) |-> (r_g != '0))
        else $error("fa_gcd: zero gcd");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("fa_gcd: done held longer than one cycle");

endmodule

// File: test/tb_top.sv
// tb_top: self-checking bench for fraction_alu_with_reduction_top, predicting each reduced fraction
// depends on fa_pkg, fa_in_if / fa_out_if (fa_if.sv) and the rtl of the block

class fraction_scoreboard;
    typedef struct {
        logic signed [fa_pkg::NUM_OUT_W-1:0] num;
        logic signed [fa_pkg::DEN_OUT_W-1:0] den;
        logic                                status;
    } t_fraction;

    t_fraction   reduced_q[$];
    int unsigned mismatches;

    function new();
        mismatches = 0;
    endfunction

    // cross-multiply or take the first fraction to reduce, then divide both parts by their gcd
    function void note_operands(logic [fa_pkg::CMD_W-1:0] cmd,
                                logic signed [15:0] an, logic signed [15:0] ad,
                                logic signed [15:0] bn, logic signed [15:0] bd);
        longint    n, d, x, y, t;
        t_fraction r;
        if (cmd[fa_pkg::CMD_RED_BIT]) begin
            n = an;
            d = ad;
        end else begin
            case (cmd)
                fa_pkg::CMD_ADD: n = longint'(an) * bd + longint'(bn) * ad;
                fa_pkg::CMD_SUB: n = longint'(an) * bd - longint'(bn) * ad;
                fa_pkg::CMD_MUL: n = longint'(an) * bn;
                default:         n = longint'(an) * bd;
            endcase
            d = (cmd == fa_pkg::CMD_DIV) ? longint'(ad) * bn : longint'(ad) * bd;
        end
        r.status = (d == 0);
        if (n == 0) begin
            r.num = 0;
            r.den = 1;
        end else begin
            x = (n < 0) ? -n : n;
            y = (d < 0) ? -d : d;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            r.num = n / x;
            r.den = d / x;
        end
        reduced_q.push_back(r);
    endfunction

    function void check_result(logic signed [fa_pkg::NUM_OUT_W-1:0] num,
                               logic signed [fa_pkg::DEN_OUT_W-1:0] den,
                               logic status);
        t_fraction e;
        if (reduced_q.size() == 0) begin
            $display("%0t: unexpected word %0d/%0d status %0b", $time, num, den, status);
            mismatches++;
            return;
        end
        e = reduced_q.pop_front();
        if (num !== e.num || den !== e.den || status !== e.status) begin
            $display("%0t: expected %0d/%0d status %0b, got %0d/%0d status %0b",
                     $time, e.num, e.den, e.status, num, den, status);
            mismatches++;
        end
    endfunction
endclass

module tb_top;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_PER_PHASE = 300;

    // codes with the reduce bit set all act as reduce
    localparam logic [fa_pkg::CMD_W-1:0] CMD_RED_ALIAS_A = fa_pkg::CMD_RED | fa_pkg::CMD_SUB;
    localparam logic [fa_pkg::CMD_W-1:0] CMD_RED_ALIAS_B = fa_pkg::CMD_RED | fa_pkg::CMD_MUL;
    localparam logic [fa_pkg::CMD_W-1:0] CMD_RED_ALIAS_C = fa_pkg::CMD_RED | fa_pkg::CMD_DIV;

    logic clk;
    logic rst_n;
    int   send_idle;
    int   recv_idle;
    int   cycle_count;

    fa_in_if  in_if();
    fa_out_if out_if();

    fraction_scoreboard sb = new();

    fraction_alu_with_reduction_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic signed [15:0] pick_operand();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) return 16'($urandom);
        else if (sel < 80) return 16'($signed($urandom_range(0, 24)) - 12);
        else if (sel < 90) return sel[0] ? 16'sh7fff : 16'sh8000;
        // small values scaled by powers of two share factors
        else return 16'($urandom_range(0, 255) << $urandom_range(0, 8));
    endfunction

    task automatic send_operands(logic [fa_pkg::CMD_W-1:0] cmd,
                                 logic signed [15:0] an, logic signed [15:0] ad,
                                 logic signed [15:0] bn, logic signed [15:0] bd);
        while ($urandom_range(0, 99) < send_idle) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.cmd   <= cmd;
        in_if.a_num <= an;
        in_if.a_den <= ad;
        in_if.b_num <= bn;
        in_if.b_den <= bd;
        do @(posedge clk); while (!in_if.ready);
        sb.note_operands(cmd, an, ad, bn, bd);
    endtask

    // result side: random back-pressure, check every accepted word
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_if.valid && out_if.ready)
                sb.check_result(out_if.result_num, out_if.result_den, out_if.status);
            out_if.ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int                       phase;
        int unsigned              r;
        logic [fa_pkg::CMD_W-1:0] cmd;

        rst_n       <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.cmd   <= fa_pkg::CMD_ADD;
        in_if.a_num <= '0;
        in_if.a_den <= '0;
        in_if.b_num <= '0;
        in_if.b_den <= '0;
        send_idle = 11;
        recv_idle = 79;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 11 : (phase == 1) ? 79 : 0;
            recv_idle = (phase == 0) ? 79 : (phase == 1) ? 11 : 0;
            if (phase == 0) begin
                send_operands(fa_pkg::CMD_ADD, 1, 2, 1, 3);
                send_operands(fa_pkg::CMD_SUB, 1, 2, 1, 2);        // zero numerator
                send_operands(fa_pkg::CMD_SUB, -1, 1, 1, 1);
                send_operands(fa_pkg::CMD_MUL, -3, 4, 2, -9);      // negative denominator kept
                send_operands(fa_pkg::CMD_MUL, 5, 0, 7, 3);        // zero denominator
                send_operands(fa_pkg::CMD_DIV, 3, 4, 0, 5);        // divide by zero fraction
                send_operands(fa_pkg::CMD_DIV, -3, 4, 0, 5);
                send_operands(fa_pkg::CMD_RED, 0, 0, 7, 7);        // zero over zero
                send_operands(fa_pkg::CMD_ADD, 1, 0, 1, 0);
                send_operands(fa_pkg::CMD_ADD, 0, 0, 0, 0);
                send_operands(fa_pkg::CMD_RED, 12, -18, -32768, 32767);
                send_operands(CMD_RED_ALIAS_A, 14, 21, 3, 5);
                send_operands(CMD_RED_ALIAS_B, -9, 6, 0, 0);
                send_operands(CMD_RED_ALIAS_C, 32767, -1, 1, 1);
                send_operands(fa_pkg::CMD_RED, -32768, -32768, 0, 0);
                send_operands(fa_pkg::CMD_ADD, -32768, -32768, -32768, -32768);
                send_operands(fa_pkg::CMD_ADD, -32768, 32767, -32768, 32767);
                send_operands(fa_pkg::CMD_SUB, 32767, -32768, -32768, 32767);
                send_operands(fa_pkg::CMD_MUL, -32768, 32767, -32768, 32767);
                send_operands(fa_pkg::CMD_DIV, 32767, -32768, -32768, 32767);
                send_operands(fa_pkg::CMD_MUL, 21845, -21846, -21846, 21845);
                send_operands(fa_pkg::CMD_DIV, -1, -1, -1, -1);
            end
            repeat (RANDOM_PER_PHASE) begin
                r = $urandom_range(0, 9);
                if (r < 8) cmd = fa_pkg::CMD_W'(r % 5);
                else cmd = fa_pkg::CMD_RED | fa_pkg::CMD_W'($urandom_range(1, 3));
                send_operands(cmd, pick_operand(), pick_operand(),
                              pick_operand(), pick_operand());
            end
            // hold off until the block has drained
            in_if.valid <= 1'b0;
            while (sb.reduced_q.size() != 0) @(posedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.reduced_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/fa_pkg.sv
hw/rtl/fa_if.sv
hw/rtl/fa_gcd.sv
hw/rtl/fraction_alu_with_reduction_top.sv
test/tb_top.sv
